### rtl/core/lnr_pkg.sv
// ----------------------------------------------------------------------------
// lnr_pkg: shared types and constants for the row layer normalizer
// Element record, back-end states, arithmetic widths, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lnr_pkg;

  localparam int MAX_FEATURES = 64;
  localparam int DATA_W       = 16;
  localparam int CNT_W        = 7;
  localparam int EPS_W        = 16;
  localparam int CFG_IDX_W    = 1;

  // divider: dividend holds 2^64, divisor holds the variance
  localparam int DVD_W        = 65;
  localparam int DVS_W        = 56;
  localparam int ROOT_W       = 64;
  localparam int INV_W        = 25;

  localparam int SUM_W        = 22;
  localparam int MEAN_W       = SUM_W + 9;
  localparam int DIFF_W       = 26;
  localparam int SQ_W         = 48;
  localparam int PROD_W       = 52;
  localparam int P_W          = 36;
  localparam int T_W          = 54;

  localparam int JOB_DEPTH    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 1'b1;

  localparam logic [CNT_W-1:0] ROW_LEN_RST = 7'd64;
  localparam logic [EPS_W-1:0] EPSILON_RST = 16'd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic signed [DATA_W-1:0] gain;
    logic signed [DATA_W-1:0] offset;
  } lnr_elem_t;

  typedef struct packed {
    logic pop;
    logic div_start;
    logic out_load;
  } lnr_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SUM_RD,
    S_SUM_ACC,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_SQ_RD,
    S_SQ_MUL,
    S_SQ_ACC,
    S_VAR_GO,
    S_VAR_WAIT,
    S_INV_GO,
    S_INV_WAIT,
    S_ROOT,
    S_OUT_RD,
    S_OUT_MUL1,
    S_OUT_MUL2,
    S_OUT_SEND
  } lnr_state_e;

endpackage

`default_nettype wire

### rtl/core/lnr_fifo.sv
// ----------------------------------------------------------------------------
// lnr_fifo: short request queue between front and back
// Holds the row length of each completed row until the back end takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lnr_fifo
  import lnr_pkg::*;
#(
  parameter int Width = CNT_W,
  parameter int Depth = JOB_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [Width-1:0]      data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != CntW'(Depth));
  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lnr_front.sv
// ----------------------------------------------------------------------------
// lnr_front: input side of the row normalizer
// Accepts elements, writes them to row storage, counts the row and queues
// a request with the row length when the row is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module lnr_front
  import lnr_pkg::*;
#(
  parameter int MaxFeatures = MAX_FEATURES
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [DATA_W-1:0]       sample_i,
  input  wire logic signed [DATA_W-1:0]       gain_i,
  input  wire logic signed [DATA_W-1:0]       offset_i,
  input  wire logic [CNT_W-1:0]               row_len_i,
  input  wire logic                           hold_i,
  output logic                                push_o,
  output logic [CNT_W-1:0]                    push_n_o,
  output logic                                wr_en_o,
  output logic [$clog2(MaxFeatures)-1:0]      wr_addr_o,
  output lnr_elem_t                           wr_data_o
);

  localparam int AddrW = $clog2(MaxFeatures);

  logic [CNT_W-1:0] count_q, count_d, count_inc, n_eff;
  logic             accept;

  // zero acts as one, anything above the storage depth as the depth
  always_comb begin
    if (row_len_i == '0) begin
      n_eff = CNT_W'(1);
    end else if (row_len_i > CNT_W'(MaxFeatures)) begin
      n_eff = CNT_W'(MaxFeatures);
    end else begin
      n_eff = row_len_i;
    end
  end

  assign in_ready_o = !hold_i;
  assign accept     = in_valid_i && !hold_i;
  assign count_inc  = count_q + 1'b1;

  assign wr_en_o   = accept && (count_q < CNT_W'(MaxFeatures));
  assign wr_addr_o = count_q[AddrW-1:0];
  assign wr_data_o = '{sample: sample_i, gain: gain_i, offset: offset_i};

  assign push_o   = accept && (count_inc >= n_eff);
  assign push_n_o = n_eff;

  always_comb begin
    count_d = count_q;
    if (accept) begin
      count_d = (count_inc >= n_eff) ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lnr_div.sv
// ----------------------------------------------------------------------------
// lnr_div: shared unsigned restoring divider
// One quotient bit per cycle; quotient valid the cycle done_o is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lnr_div
  import lnr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quotient_o
);

  localparam int StepW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d, dvs_q;
  logic [DVS_W:0]   rem_sh, rem_sub;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic             ge;

  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[DVD_W-2:0], ge};
      // remainder stays below the divisor, so the top bit drops
      rem_d  = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == StepW'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### rtl/core/lnr_back.sv
// ----------------------------------------------------------------------------
// lnr_back: row statistics and output engine
// Holds the row store, walks it for mean, variance and output, and runs the
// shared divider and a digit-by-digit square root per row.
// ----------------------------------------------------------------------------
`default_nettype none

module lnr_back
  import lnr_pkg::*;
#(
  parameter int MaxFeatures = MAX_FEATURES
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           job_valid_i,
  input  wire logic [CNT_W-1:0]               job_n_i,
  output logic                                job_pop_o,
  input  wire logic [EPS_W-1:0]               epsilon_i,
  input  wire logic                           wr_en_i,
  input  wire logic [$clog2(MaxFeatures)-1:0] wr_addr_i,
  input  wire lnr_elem_t                      wr_data_i,
  output logic                                busy_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [DATA_W-1:0]            normalized_o,
  output logic                                last_of_row_o,
  output logic                                clipped_o
);

  localparam int AddrW = $clog2(MaxFeatures);

  lnr_state_e state_q, state_d;
  lnr_ctrl_t  ctrl;

  lnr_elem_t  mem_q [MaxFeatures];
  lnr_elem_t  rd_q;

  logic [CNT_W-1:0]          n_q;
  logic [AddrW-1:0]          idx_q;
  logic                      last_elem;
  logic signed [SUM_W-1:0]   sum_q;
  logic signed [MEAN_W-1:0]  mean_q;
  logic                      neg_q;
  logic [SQ_W-1:0]           sq_q;
  logic [DVS_W-1:0]          acc_q, var_q;
  logic [ROOT_W-1:0]         rrem_q, root_q, bit_q;
  logic [ROOT_W-1:0]         root_try, root_nxt;
  logic                      root_ge;
  logic [INV_W-1:0]          inv_q;
  logic signed [PROD_W-1:0]  prod1_q, prod2_q;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  diff_sq, diff_inv, p_gain;
  logic signed [P_W-1:0]     p_val;
  logic signed [T_W-1:0]     t_val;
  logic signed [T_W-17:0]    r_val;
  logic signed [DVD_W-1:0]   mean_sc;
  logic [DVD_W-1:0]          div_dividend;
  logic [DVS_W-1:0]          div_divisor;
  logic                      div_done;
  logic [DVD_W-1:0]          div_quo;
  logic signed [MEAN_W-1:0]  quo_mean;
  logic                      slot_free;
  logic signed [DATA_W-1:0]  sat_val;
  logic                      sat_flag;

  assign last_elem = (CNT_W'(idx_q) + 1'b1) == n_q;
  assign slot_free = !out_valid_o || out_ready_i;
  assign busy_o    = (state_q != S_IDLE);
  assign job_pop_o = ctrl.pop;

  // row store: one write port from the front, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[idx_q];
  end

  lnr_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (ctrl.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (job_valid_i) state_d = S_SUM_RD;
      S_SUM_RD:    state_d = S_SUM_ACC;
      S_SUM_ACC:   state_d = last_elem ? S_MEAN_GO : S_SUM_RD;
      S_MEAN_GO:   state_d = S_MEAN_WAIT;
      S_MEAN_WAIT: if (div_done) state_d = S_SQ_RD;
      S_SQ_RD:     state_d = S_SQ_MUL;
      S_SQ_MUL:    state_d = S_SQ_ACC;
      S_SQ_ACC:    state_d = last_elem ? S_VAR_GO : S_SQ_RD;
      S_VAR_GO:    state_d = S_VAR_WAIT;
      S_VAR_WAIT:  if (div_done) state_d = S_INV_GO;
      S_INV_GO:    state_d = (var_q <= DVS_W'(1)) ? S_OUT_RD : S_INV_WAIT;
      S_INV_WAIT:  if (div_done) state_d = S_ROOT;
      S_ROOT:      if (bit_q[0]) state_d = S_OUT_RD;
      S_OUT_RD:    state_d = S_OUT_MUL1;
      S_OUT_MUL1:  state_d = S_OUT_MUL2;
      S_OUT_MUL2:  state_d = S_OUT_SEND;
      S_OUT_SEND: begin
        if (slot_free) state_d = last_elem ? S_IDLE : S_OUT_RD;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl         = '0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state_q)
      S_IDLE:     ctrl.pop = job_valid_i;
      S_MEAN_GO: begin
        ctrl.div_start = 1'b1;
        div_dividend   = (sum_q < 0) ? DVD_W'(-mean_sc + DVD_W'(n_q) - 1) : DVD_W'(mean_sc);
        div_divisor    = DVS_W'(n_q);
      end
      S_VAR_GO: begin
        ctrl.div_start = 1'b1;
        div_dividend   = DVD_W'(acc_q);
        div_divisor    = DVS_W'(n_q);
      end
      S_INV_GO: begin
        ctrl.div_start = (var_q > DVS_W'(1));
        div_dividend   = DVD_W'(1) << (DVD_W - 1);
        div_divisor    = var_q;
      end
      S_OUT_SEND: ctrl.out_load = slot_free;
      default: ;
    endcase
  end

  // datapath helpers
  assign mean_sc  = DVD_W'(sum_q) <<< 8;
  assign quo_mean = MEAN_W'(div_quo);
  assign diff     = (DIFF_W'(rd_q.sample) <<< 8) - DIFF_W'(mean_q);
  assign diff_sq  = diff * diff;
  assign diff_inv = diff * $signed({1'b0, inv_q});
  assign p_val    = P_W'(prod1_q >>> 16);
  assign p_gain   = p_val * rd_q.gain;
  assign t_val    = T_W'(prod2_q) + (T_W'(rd_q.offset) <<< 16) + T_W'(32768);
  assign r_val    = t_val[T_W-1:16];

  assign root_try = root_q + bit_q;
  assign root_ge  = rrem_q >= root_try;
  assign root_nxt = root_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);

  always_comb begin
    sat_flag = 1'b0;
    sat_val  = DATA_W'(r_val);
    if (r_val > (T_W-16)'(32767)) begin
      sat_flag = 1'b1;
      sat_val  = 16'sh7fff;
    end else if (r_val < -(T_W-16)'(32768)) begin
      sat_flag = 1'b1;
      sat_val  = 16'sh8000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        n_q   <= job_n_i;
        idx_q <= '0;
        sum_q <= '0;
        acc_q <= '0;
      end
      S_SUM_ACC: begin
        sum_q <= sum_q + SUM_W'(rd_q.sample);
        idx_q <= last_elem ? '0 : idx_q + 1'b1;
      end
      S_MEAN_GO:   neg_q <= (sum_q < 0);
      S_MEAN_WAIT: if (div_done) mean_q <= neg_q ? -quo_mean : quo_mean;
      S_SQ_MUL:    sq_q <= SQ_W'(diff_sq);
      S_SQ_ACC: begin
        acc_q <= acc_q + DVS_W'(sq_q);
        idx_q <= last_elem ? '0 : idx_q + 1'b1;
      end
      S_VAR_WAIT: begin
        if (div_done) var_q <= DVS_W'(div_quo) + (DVS_W'(epsilon_i) << 16);
      end
      S_INV_GO: inv_q <= INV_W'(1) << (INV_W - 1);
      S_INV_WAIT: begin
        rrem_q <= div_quo[ROOT_W-1:0];
        root_q <= '0;
        bit_q  <= ROOT_W'(1) << (ROOT_W - 2);
      end
      S_ROOT: begin
        if (root_ge) rrem_q <= rrem_q - root_try;
        root_q <= root_nxt;
        bit_q  <= bit_q >> 2;
        if (bit_q[0]) begin
          inv_q <= (root_nxt > (ROOT_W'(1) << (INV_W - 1))) ?
                   (INV_W'(1) << (INV_W - 1)) : INV_W'(root_nxt);
        end
      end
      S_OUT_MUL1: prod1_q <= diff_inv;
      S_OUT_MUL2: prod2_q <= p_gain;
      S_OUT_SEND: begin
        if (ctrl.out_load) begin
          normalized_o  <= sat_val;
          clipped_o     <= sat_flag;
          last_of_row_o <= last_elem;
          idx_q         <= idx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/layer_norm_row_normalizer.sv
// ----------------------------------------------------------------------------
// layer_norm_row_normalizer: fixed-point row layer normalization
//
// Input channel (in_valid_i/in_ready_o) takes one Q8.8 sample with its
// gain and offset per request. After a full row of requests the row is
// normalized and the output channel (out_valid_o/out_ready_i) returns one
// request per element, last_of_row_o marking the final one, clipped_o
// marking saturation. Config writes (cfg_we_i) set the row length (index 0)
// and epsilon (index 1); write them only while the block is idle.
// Row processing makes three walks of the row store, three passes of the
// shared divider (mean, variance, 2^64/variance) and a 32-step square
// root; the last divider pass and the root are skipped when the variance
// is at most one. Inputs stall during row processing.
// An output register holds each result; a stalled receiver stalls the
// output walk, and with it the input. Reset clears counters and state,
// sets the row length to 64 and epsilon to 1; row storage is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_norm_row_normalizer
  import lnr_pkg::*;
#(
  parameter int MaxFeatures = MAX_FEATURES
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [EPS_W-1:0]         cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [DATA_W-1:0] sample_i,
  input  wire logic signed [DATA_W-1:0] gain_i,
  input  wire logic signed [DATA_W-1:0] offset_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      normalized_o,
  output logic                          last_of_row_o,
  output logic                          clipped_o
);

  localparam int AddrW = $clog2(MaxFeatures);

  logic [CNT_W-1:0] row_len_q;
  logic [EPS_W-1:0] epsilon_q;

  logic             push, job_valid, job_pop, back_busy, hold;
  logic [CNT_W-1:0] push_n, job_n;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  lnr_elem_t        wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= ROW_LEN_RST;
      epsilon_q <= EPSILON_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW_LEN: row_len_q <= cfg_data_i[CNT_W-1:0];
        CFG_EPSILON: epsilon_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // row store is shared: the front waits while a row is pending or in work
  assign hold = back_busy || job_valid;

  lnr_front #(.MaxFeatures(MaxFeatures)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sample_i,
    .gain_i,
    .offset_i,
    .row_len_i       (row_len_q),
    .hold_i          (hold),
    .push_o          (push),
    .push_n_o        (push_n),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data)
  );

  lnr_fifo #(.Width(CNT_W), .Depth(JOB_DEPTH)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_n),
    .pop_i       (job_pop),
    .valid_o     (job_valid),
    .data_o      (job_n)
  );

  lnr_back #(.MaxFeatures(MaxFeatures)) u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (job_valid),
    .job_n_i     (job_n),
    .job_pop_o   (job_pop),
    .epsilon_i   (epsilon_q),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .busy_o      (back_busy),
    .out_valid_o,
    .out_ready_i,
    .normalized_o,
    .last_of_row_o,
    .clipped_o
  );

  a_store_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !back_busy && !job_valid)
    else $error("row store written while a row is in work");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |->
      (normalized_o == 16'sh7fff) || (normalized_o == 16'sh8000))
    else $error("clipped result not at a saturation limit");

  a_push_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !in_ready_o)
    else $error("input accepted right after a row was queued");

endmodule

`default_nettype wire

### tb/sv/layer_norm_row_normalizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// layer_norm_row_normalizer_tb: self-checking bench for the row normalizer
// Drives rows of Q8.8 samples with gain and offset under bursty input and a
// stalling receiver. A scoreboard recomputes mean, variance, inverse root and
// each rounded, saturated element, and compares every output request in order.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_norm_row_normalizer_tb
  import lnr_pkg::*;
;

  typedef struct {
    logic signed [DATA_W-1:0] normalized;
    logic                     last_of_row;
    logic                     clipped;
  } norm_result_t;

  class norm_scoreboard;
    int unsigned  row_len = 64;
    int unsigned  epsilon = 1;
    int           row_samples[MAX_FEATURES];
    int           row_gains[MAX_FEATURES];
    int           row_offsets[MAX_FEATURES];
    int unsigned  element_count = 0;
    norm_result_t pending[$];
    int           errors = 0;

    function automatic longint floor_div(longint a, longint n);
      if (a >= 0) return a / n;
      return -((-a + n - 1) / n);
    endfunction

    // 1/sqrt(v) with 16 fraction bits, truncated, capped at 2^24
    function automatic longint unsigned inv_root(longint unsigned v);
      logic [127:0] q;
      logic [127:0] y;
      logic [127:0] cand;
      if (v <= 1) return 64'd1 << 24;
      q = (128'd1 << 64) / v;
      y = '0;
      for (int b = 33; b >= 0; b--) begin
        cand = y | (128'd1 << b);
        if (cand * cand <= q) y = cand;
      end
      if (y > (128'd1 << 24)) y = 128'd1 << 24;
      return y[63:0];
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [EPS_W-1:0] data);
      if (idx == CFG_ROW_LEN) row_len = 32'(data[CNT_W-1:0]);
      else epsilon = 32'(data);
    endfunction

    function void note_request(logic signed [DATA_W-1:0] s, logic signed [DATA_W-1:0] g,
                               logic signed [DATA_W-1:0] o);
      int unsigned       n;
      longint            sum;
      longint            mean16;
      longint            d;
      longint            p;
      longint            t;
      longint            r;
      longint unsigned   sumsq;
      longint unsigned   v;
      longint            inv;
      norm_result_t      res;
      n = row_len;
      if (n == 0) n = 1;
      if (n > MAX_FEATURES) n = MAX_FEATURES;
      if (element_count < MAX_FEATURES) begin
        row_samples[element_count] = int'(s);
        row_gains[element_count]   = int'(g);
        row_offsets[element_count] = int'(o);
      end
      element_count = (element_count + 1) & 7'h7f;
      if (element_count < n) return;
      element_count = 0;
      sum = 0;
      for (int i = 0; i < n; i++) sum += row_samples[i];
      mean16 = floor_div(sum * 256, longint'(n));
      sumsq = 0;
      for (int i = 0; i < n; i++) begin
        d = longint'(row_samples[i]) * 256 - mean16;
        sumsq += longint'(d * d);
      end
      v = sumsq / n + (longint'(epsilon) << 16);
      inv = longint'(inv_root(v));
      for (int i = 0; i < n; i++) begin
        d = longint'(row_samples[i]) * 256 - mean16;
        p = (d * inv) >>> 16;
        t = p * row_gains[i] + longint'(row_offsets[i]) * 65536;
        r = (t + 32768) >>> 16;
        res.clipped = 1'b0;
        if (r > 32767) begin
          r = 32767;
          res.clipped = 1'b1;
        end else if (r < -32768) begin
          r = -32768;
          res.clipped = 1'b1;
        end
        res.normalized  = r[DATA_W-1:0];
        res.last_of_row = (i + 1 == n);
        pending.push_back(res);
      end
    endfunction

    task report(string what);
      errors++;
      $display("ERROR @%0t: %s", $time, what);
    endtask

    task check_result(logic signed [DATA_W-1:0] nrm, logic lst, logic clp);
      norm_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result normalized=%0d", nrm));
        return;
      end
      e = pending.pop_front();
      if (nrm !== e.normalized)
        report($sformatf("normalized got %0d exp %0d", nrm, e.normalized));
      if (lst !== e.last_of_row)
        report($sformatf("last_of_row got %b exp %b", lst, e.last_of_row));
      if (clp !== e.clipped)
        report($sformatf("clipped got %b exp %b", clp, e.clipped));
    endtask
  endclass

  localparam int IDLE_LIMIT = 20000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [EPS_W-1:0]         cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] sample_i;
  logic signed [DATA_W-1:0] gain_i;
  logic signed [DATA_W-1:0] offset_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] normalized_o;
  logic                     last_of_row_o;
  logic                     clipped_o;

  norm_scoreboard sb = new();
  int             sent = 0;
  int             idle_cycles = 0;
  bit             burst_mode = 1'b1;
  bit             long_hold = 1'b0;

  layer_norm_row_normalizer i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .sample_i, .gain_i, .offset_i,
    .out_valid_o, .out_ready_i, .normalized_o, .last_of_row_o, .clipped_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: shifting stall pattern, one long hold-off on request
  initial begin
    int mode;
    mode = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i = 1'b0;
        repeat (1500) @(negedge clk_i);
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = ($urandom_range(0, 9) < 7);
        default: out_ready_i = ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(normalized_o, last_of_row_o, clipped_o);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [EPS_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task send_elem(logic signed [DATA_W-1:0] s, logic signed [DATA_W-1:0] g,
                 logic signed [DATA_W-1:0] o);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    sample_i   = s;
    gain_i     = g;
    offset_i   = o;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(s, g, o);
    sent++;
    // bursty sender: sometimes drop valid for a few cycles
    if (burst_mode && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
    end
  endtask

  // hold the sender until every expected result is back, then settle
  task drain;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task send_row(int n, int style);
    logic signed [DATA_W-1:0] base;
    logic signed [DATA_W-1:0] s;
    logic signed [DATA_W-1:0] g;
    base = 16'($urandom());
    for (int i = 0; i < n; i++) begin
      if (style == 0) begin
        s = 16'($urandom());
        g = 16'($urandom());
      end else begin
        s = base + $signed(16'($urandom_range(0, 511))) - 16'sd256;
        g = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      end
      send_elem(s, g, 16'($urandom()));
    end
  endtask

  initial begin
    int fc;
    int n;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_ROW_LEN;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    gain_i      = '0;
    offset_i    = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes that saturate both ways
    write_reg(CFG_ROW_LEN, 16'd4);
    send_elem(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_elem(-16'sh8000, 16'sh7fff, -16'sh8000);
    send_elem(16'sd0, -16'sh8000, 16'sd0);
    send_elem(16'sd1, -16'sh8000, 16'sh7fff);
    drain();
    // flat row with zero epsilon: inverse root pinned at its cap
    write_reg(CFG_EPSILON, 16'd0);
    write_reg(CFG_ROW_LEN, 16'd2);
    send_elem(16'sd300, 16'sd256, 16'sd10);
    send_elem(16'sd300, -16'sd256, -16'sd10);
    drain();
    // row length zero acts as one
    write_reg(CFG_ROW_LEN, 16'd0);
    write_reg(CFG_EPSILON, 16'hffff);
    send_elem(16'sh1234, 16'sh7fff, 16'sh4321);
    send_elem(-16'sh8000, 16'sh0100, -16'sh8000);
    drain();
    // lowering the length in mid-row
    write_reg(CFG_ROW_LEN, 16'd8);
    write_reg(CFG_EPSILON, 16'd1);
    send_row(5, 1);
    drain();
    write_reg(CFG_ROW_LEN, 16'd3);
    send_row(1, 1);
    drain();
    // length above the maximum acts as the maximum
    write_reg(CFG_ROW_LEN, 16'd100);
    send_row(64, 1);
    drain();
    // receiver holds off while rows keep coming, so the input stalls
    write_reg(CFG_ROW_LEN, 16'd4);
    long_hold = 1'b1;
    repeat (3) send_row(4, 1);
    drain();

    // random phases
    while (sent < 104) begin
      case ($urandom_range(0, 7))
        0: fc = 0;
        default: fc = $urandom_range(1, 8);
      endcase
      n = (fc == 0) ? 1 : (fc > MAX_FEATURES ? MAX_FEATURES : fc);
      write_reg(CFG_ROW_LEN, 16'(fc));
      case ($urandom_range(0, 5))
        0: write_reg(CFG_EPSILON, 16'd0);
        1: write_reg(CFG_EPSILON, 16'hffff);
        default: write_reg(CFG_EPSILON, 16'($urandom()));
      endcase
      burst_mode = ($urandom_range(0, 3) != 0);
      repeat ((n > 8) ? 1 : $urandom_range(1, 3)) send_row(n, $urandom_range(0, 2) == 0 ? 0 : 1);
      drain();
    end

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
